// File: rtl/acpu_pkg.sv
// Package for the accumulator CPU step block: item kinds, opcodes, status codes,
// sequencer states and the instruction decode and ALU functions.
// No dependencies.
`default_nettype none

package acpu_pkg;

    localparam int MEM_DEPTH_DEF = 256;

    // Request kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_RUN   = 2'd0;
    localparam logic [1:0] STAT_HALT  = 2'd1;
    localparam logic [1:0] STAT_FAULT = 2'd2;

    // Opcodes
    localparam logic [7:0] OPC_LOAD_IMM  = 8'h00;
    localparam logic [7:0] OPC_LOAD_DIR  = 8'h40;
    localparam logic [7:0] OPC_LOAD_IND  = 8'hC0;
    localparam logic [7:0] OPC_ADD_IMM   = 8'h20;
    localparam logic [7:0] OPC_ADD_DIR   = 8'h60;
    localparam logic [7:0] OPC_ADD_IND   = 8'hE0;
    localparam logic [7:0] OPC_SUB_IMM   = 8'h21;
    localparam logic [7:0] OPC_SUB_DIR   = 8'h61;
    localparam logic [7:0] OPC_SUB_IND   = 8'hE1;
    localparam logic [7:0] OPC_NAND_IMM  = 8'h22;
    localparam logic [7:0] OPC_NAND_DIR  = 8'h62;
    localparam logic [7:0] OPC_NAND_IND  = 8'hE2;
    localparam logic [7:0] OPC_STORE_DIR = 8'h48;
    localparam logic [7:0] OPC_STORE_IND = 8'hC8;
    localparam logic [7:0] OPC_IN_DIR    = 8'h49;
    localparam logic [7:0] OPC_IN_IND    = 8'hC9;
    localparam logic [7:0] OPC_OUT_DIR   = 8'h41;
    localparam logic [7:0] OPC_OUT_IND   = 8'hC1;
    localparam logic [7:0] OPC_JUMP      = 8'h10;
    localparam logic [7:0] OPC_BRN       = 8'h11;
    localparam logic [7:0] OPC_BRZ       = 8'h12;

    typedef enum logic [3:0] {
        OC_LOAD,
        OC_ADD,
        OC_SUB,
        OC_NAND,
        OC_STORE,
        OC_IN,
        OC_OUT,
        OC_JUMP,
        OC_BRN,
        OC_BRZ,
        OC_ILL
    } opclass_t;

    typedef enum logic [1:0] {
        MODE_IMM,
        MODE_DIR,
        MODE_IND
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CODE,
        S_OPND,
        S_RD1,
        S_RD2,
        S_DONE
    } state_t;

    function automatic opclass_t decode_op(input logic [7:0] code);
        opclass_t c;
        case (code)
            OPC_LOAD_IMM, OPC_LOAD_DIR, OPC_LOAD_IND: c = OC_LOAD;
            OPC_ADD_IMM, OPC_ADD_DIR, OPC_ADD_IND:    c = OC_ADD;
            OPC_SUB_IMM, OPC_SUB_DIR, OPC_SUB_IND:    c = OC_SUB;
            OPC_NAND_IMM, OPC_NAND_DIR, OPC_NAND_IND: c = OC_NAND;
            OPC_STORE_DIR, OPC_STORE_IND:             c = OC_STORE;
            OPC_IN_DIR, OPC_IN_IND:                   c = OC_IN;
            OPC_OUT_DIR, OPC_OUT_IND:                 c = OC_OUT;
            OPC_JUMP:                                 c = OC_JUMP;
            OPC_BRN:                                  c = OC_BRN;
            OPC_BRZ:                                  c = OC_BRZ;
            default:                                  c = OC_ILL;
        endcase
        return c;
    endfunction

    function automatic mode_t decode_mode(input logic [7:0] code);
        mode_t m;
        if (code[7])
        begin
            m = MODE_IND;
        end
        else if (code[6])
        begin
            m = MODE_DIR;
        end
        else
        begin
            m = MODE_IMM;
        end
        return m;
    endfunction

    function automatic logic [7:0] alu(input opclass_t c, input logic [7:0] a,
                                       input logic [7:0] v);
        logic [7:0] r;
        case (c)
            OC_LOAD: r = v;
            OC_ADD:  r = a + v;
            OC_SUB:  r = a - v;
            OC_NAND: r = ~(a & v);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/acpu_if.sv
// Request and response channel interfaces for the accumulator CPU step block.
// Valid/ready handshake with the payload fields; no package dependency.
`default_nettype none

interface acpu_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] address;
    logic [7:0] data;

    modport source (output valid, output kind, output address, output data, input ready);
    modport sink (input valid, input kind, input address, input data, output ready);
endinterface

interface acpu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pc_value;
    logic [7:0] acc_value;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] status;

    modport source (output valid, output pc_value, output acc_value, output out_valid,
                    output out_byte, output status, input ready);
    modport sink (input valid, input pc_value, input acc_value, input out_valid,
                  input out_byte, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/acpu_mem.sv
// Single-port main memory with registered read data.
// The 8-bit address is reduced modulo MEM_DEPTH. Depends on acpu_pkg.
`default_nettype none

module acpu_mem
    import acpu_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic       we,
    input  wire logic [7:0] addr,
    input  wire logic [7:0] wdata,
    output logic [7:0]      rdata
);

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int RECIP = (65536 + MEM_DEPTH - 1) / MEM_DEPTH;

    logic [7:0]  mem_array [MEM_DEPTH];
    logic [7:0]  rdata_reg;
    logic [20:0] quot_prod;
    logic [4:0]  quot;
    logic [8:0]  rem;
    logic [AW-1:0] idx;

    // addr / MEM_DEPTH by reciprocal multiply; exact for 8-bit addresses when MEM_DEPTH >= 8
    assign quot_prod = 21'(addr) * 21'(RECIP);
    assign quot      = quot_prod[20:16];
    assign rem       = {1'b0, addr} - 9'(quot * MEM_DEPTH);
    assign idx       = rem[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[idx] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[idx];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/accumulator_cpu_step.sv
// Top level of the accumulator CPU step block: request sequencer, PC,
// accumulator, fault flag and response register. Uses acpu_pkg, acpu_if, acpu_mem.
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------
//  req     | in  | kind, address, data
//  rsp     | out | pc_value, acc_value, out_valid, out_byte, status
//
// A load, start or unused-kind request, or an execute request while faulted, goes
// straight to the done state; an execute request reads the opcode and operand, then
// a pointer and a value, one value, a pointer then a write, one write or nothing,
// all serialized on the single port of the main memory. One request in flight.
// Reset clears PC, accumulator and fault flag; memory contents are undefined.
// The response register holds a result while the next request is taken; a
// finished request waits in its last state while rsp is stalled.
`default_nettype none

module accumulator_cpu_step
    import acpu_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    acpu_req_if.sink   req,
    acpu_rsp_if.source rsp
);

    state_t     state_reg, state_next;
    logic [7:0] pc_reg, pc_next;
    logic [7:0] acc_reg, acc_next;
    logic       fault_reg, fault_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] in_data_reg, in_data_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic [7:0] rsp_pc_reg, rsp_pc_next;
    logic [7:0] rsp_acc_reg, rsp_acc_next;
    logic       rsp_ov_reg, rsp_ov_next;
    logic [7:0] rsp_ob_reg, rsp_ob_next;
    logic [1:0] rsp_status_reg, rsp_status_next;

    logic       mem_en, mem_we;
    logic [7:0] mem_addr, mem_wdata, mem_rdata;

    logic       req_fire;
    logic       slot_free;
    opclass_t   op_class;
    mode_t      op_mode;
    logic       is_write;
    logic [7:0] pc_inc, pc_two;
    logic [7:0] wr_byte;

    acpu_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign op_class = decode_op(code_reg);
    assign op_mode  = decode_mode(code_reg);
    assign is_write = (op_class == OC_STORE) || (op_class == OC_IN);
    assign wr_byte  = (op_class == OC_STORE) ? acc_reg : in_data_reg;
    assign pc_inc   = pc_reg + 8'd1;
    assign pc_two   = pc_reg + 8'd2;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == KIND_EXEC && !fault_reg)
                    begin
                        state_next = S_CODE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CODE: state_next = S_OPND;
            S_OPND:
            begin
                case (op_class)
                    OC_JUMP, OC_BRN, OC_BRZ, OC_ILL: state_next = S_DONE;
                    default:
                    begin
                        if (op_mode == MODE_IMM || (op_mode == MODE_DIR && is_write))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD1;
                        end
                    end
                endcase
            end
            S_RD1:
            begin
                if (op_mode == MODE_IND && !is_write)
                begin
                    state_next = S_RD2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD2: state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory port and response register
    always_comb
    begin
        pc_next         = pc_reg;
        acc_next        = acc_reg;
        fault_next      = fault_reg;
        code_next       = code_reg;
        in_data_next    = in_data_reg;
        ov_next         = ov_reg;
        ob_next         = ob_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_pc_next     = rsp_pc_reg;
        rsp_acc_next    = rsp_acc_reg;
        rsp_ov_next     = rsp_ov_reg;
        rsp_ob_next     = rsp_ob_reg;
        rsp_status_next = rsp_status_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = pc_reg;
        mem_wdata       = wr_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    in_data_next = req.data;
                    ov_next      = 1'b0;
                    ob_next      = 8'd0;
                    case (req.kind)
                        KIND_LOAD:
                        begin
                            mem_en    = 1'b1;
                            mem_we    = 1'b1;
                            mem_addr  = req.address;
                            mem_wdata = req.data;
                        end
                        KIND_START:
                        begin
                            pc_next    = req.address;
                            acc_next   = 8'd0;
                            fault_next = 1'b0;
                        end
                        KIND_EXEC:
                        begin
                            if (!fault_reg)
                            begin
                                mem_en   = 1'b1;
                                mem_addr = pc_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CODE:
            begin
                code_next = mem_rdata;
                mem_en    = 1'b1;
                mem_addr  = pc_inc;
            end
            S_OPND:
            begin
                // mem_rdata is the operand byte
                case (op_class)
                    OC_JUMP: pc_next = mem_rdata;
                    OC_BRN:  pc_next = acc_reg[7] ? mem_rdata : pc_two;
                    OC_BRZ:  pc_next = (acc_reg == 8'd0) ? mem_rdata : pc_two;
                    OC_ILL:  fault_next = 1'b1;
                    default:
                    begin
                        if (op_mode == MODE_IMM)
                        begin
                            acc_next = alu(op_class, acc_reg, mem_rdata);
                            pc_next  = pc_two;
                        end
                        else if (op_mode == MODE_DIR && is_write)
                        begin
                            mem_en   = 1'b1;
                            mem_we   = 1'b1;
                            mem_addr = mem_rdata;
                            pc_next  = pc_two;
                        end
                        else
                        begin
                            mem_en   = 1'b1;
                            mem_addr = mem_rdata;
                        end
                    end
                endcase
            end
            S_RD1:
            begin
                if (op_mode == MODE_IND && is_write)
                begin
                    mem_en   = 1'b1;
                    mem_we   = 1'b1;
                    mem_addr = mem_rdata;
                    pc_next  = pc_two;
                end
                else if (op_mode == MODE_IND)
                begin
                    mem_en   = 1'b1;
                    mem_addr = mem_rdata;
                end
                else
                begin
                    if (op_class == OC_OUT)
                    begin
                        ov_next = 1'b1;
                        ob_next = mem_rdata;
                    end
                    else
                    begin
                        acc_next = alu(op_class, acc_reg, mem_rdata);
                    end
                    pc_next = pc_two;
                end
            end
            S_RD2:
            begin
                if (op_class == OC_OUT)
                begin
                    ov_next = 1'b1;
                    ob_next = mem_rdata;
                end
                else
                begin
                    acc_next = alu(op_class, acc_reg, mem_rdata);
                end
                pc_next = pc_two;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_pc_next    = pc_reg;
                    rsp_acc_next   = acc_reg;
                    rsp_ov_next    = ov_reg;
                    rsp_ob_next    = ob_reg;
                    if (fault_reg)
                    begin
                        rsp_status_next = STAT_FAULT;
                    end
                    else if (pc_reg == 8'd0)
                    begin
                        rsp_status_next = STAT_HALT;
                    end
                    else
                    begin
                        rsp_status_next = STAT_RUN;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 8'd0;
            acc_reg       <= 8'd0;
            fault_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            fault_reg     <= fault_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        in_data_reg    <= in_data_next;
        ov_reg         <= ov_next;
        ob_reg         <= ob_next;
        rsp_pc_reg     <= rsp_pc_next;
        rsp_acc_reg    <= rsp_acc_next;
        rsp_ov_reg     <= rsp_ov_next;
        rsp_ob_reg     <= rsp_ob_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.pc_value  = rsp_pc_reg;
    assign rsp.acc_value = rsp_acc_reg;
    assign rsp.out_valid = rsp_ov_reg;
    assign rsp.out_byte  = rsp_ob_reg;
    assign rsp.status    = rsp_status_reg;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for accumulator_cpu_step: drives load, start and execute
// requests on acpu_req_if; a scoreboard class checks responses on acpu_rsp_if.
// Depends on acpu_pkg, acpu_if and the RTL of accumulator_cpu_step.
`timescale 1ns / 1ps

import acpu_pkg::*;

typedef struct packed {
    logic [7:0] pc_value;
    logic [7:0] acc_value;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] status;
} machine_state_t;

class cpu_step_scoreboard;
    logic [7:0]     mem [256];
    bit             written [256];
    logic [7:0]     pc_q;
    logic [7:0]     acc_q;
    bit             fault_q;
    machine_state_t pending_states [$];
    int             error_count;

    function new();
        for (int i = 0; i < 256; i++)
        begin
            mem[i] = 8'h00;
            written[i] = 1'b0;
        end
        pc_q = 8'h00;
        acc_q = 8'h00;
        fault_q = 1'b0;
        error_count = 0;
    endfunction

    function opclass_t op_class(logic [7:0] code);
        opclass_t cls;
        cls = OC_ILL;
        if (code == OPC_JUMP)
        begin
            cls = OC_JUMP;
        end
        else if (code == OPC_BRN)
        begin
            cls = OC_BRN;
        end
        else if (code == OPC_BRZ)
        begin
            cls = OC_BRZ;
        end
        else if (!(code[7] && !code[6]))
        begin
            // low six bits pick the operation; memory-only ops need bit 6
            case (code[5:0])
                OPC_LOAD_IMM[5:0]:  cls = OC_LOAD;
                OPC_ADD_IMM[5:0]:   cls = OC_ADD;
                OPC_SUB_IMM[5:0]:   cls = OC_SUB;
                OPC_NAND_IMM[5:0]:  cls = OC_NAND;
                OPC_STORE_DIR[5:0]: cls = code[6] ? OC_STORE : OC_ILL;
                OPC_IN_DIR[5:0]:    cls = code[6] ? OC_IN : OC_ILL;
                OPC_OUT_DIR[5:0]:   cls = code[6] ? OC_OUT : OC_ILL;
                default:            cls = OC_ILL;
            endcase
        end
        return cls;
    endfunction

    function mode_t op_mode(logic [7:0] code);
        return code[7] ? MODE_IND : (code[6] ? MODE_DIR : MODE_IMM);
    endfunction

    // First memory byte the next execute would read before it was ever written.
    function bit find_unwritten_read(output logic [7:0] where, output bit is_code);
        logic [7:0] opnd;
        opclass_t   cls;
        mode_t      md;
        bit         reads_value;
        bit         reads_pointer;
        is_code = 1'b1;
        where = pc_q;
        if (!written[where])
        begin
            return 1'b1;
        end
        is_code = 1'b0;
        where = pc_q + 8'd1;
        if (!written[where] || fault_q)
        begin
            return !written[where];
        end
        opnd = mem[where];
        cls = op_class(mem[pc_q]);
        md = op_mode(mem[pc_q]);
        reads_value = (cls == OC_LOAD || cls == OC_ADD || cls == OC_SUB || cls == OC_NAND ||
                       cls == OC_OUT) && md != MODE_IMM;
        reads_pointer = md == MODE_IND && (reads_value || cls == OC_STORE || cls == OC_IN);
        where = opnd;
        if ((reads_value || reads_pointer) && !written[where])
        begin
            return 1'b1;
        end
        where = mem[opnd];
        return reads_value && md == MODE_IND && !written[where];
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] addr, logic [7:0] data);
        machine_state_t next_state;
        logic [7:0]     code;
        logic [7:0]     opnd;
        logic [7:0]     fall_through;
        logic [7:0]     target;
        logic [7:0]     value;
        opclass_t       cls;
        mode_t          md;
        next_state.out_valid = 1'b0;
        next_state.out_byte = 8'h00;
        if (kind == KIND_LOAD)
        begin
            mem[addr] = data;
            written[addr] = 1'b1;
        end
        else if (kind == KIND_START)
        begin
            pc_q = addr;
            acc_q = 8'h00;
            fault_q = 1'b0;
        end
        else if (kind == KIND_EXEC && !fault_q)
        begin
            code = mem[pc_q];
            opnd = mem[pc_q + 8'd1];
            fall_through = pc_q + 8'd2;
            cls = op_class(code);
            md = op_mode(code);
            target = (md == MODE_IND) ? mem[opnd] : opnd;
            value = (md == MODE_IMM) ? opnd : mem[target];
            case (cls)
                OC_JUMP: pc_q = opnd;
                OC_BRN:  pc_q = acc_q[7] ? opnd : fall_through;
                OC_BRZ:  pc_q = (acc_q == 8'h00) ? opnd : fall_through;
                OC_ILL:  fault_q = 1'b1;
                default:
                begin
                    case (cls)
                        OC_LOAD: acc_q = value;
                        OC_ADD:  acc_q = acc_q + value;
                        OC_SUB:  acc_q = acc_q - value;
                        OC_NAND: acc_q = ~(acc_q & value);
                        OC_STORE:
                        begin
                            mem[target] = acc_q;
                            written[target] = 1'b1;
                        end
                        OC_IN:
                        begin
                            mem[target] = data;
                            written[target] = 1'b1;
                        end
                        default:
                        begin
                            next_state.out_valid = 1'b1;
                            next_state.out_byte = mem[target];
                        end
                    endcase
                    pc_q = fall_through;
                end
            endcase
        end
        next_state.pc_value = pc_q;
        next_state.acc_value = acc_q;
        next_state.status = fault_q ? STAT_FAULT : (pc_q == 8'h00 ? STAT_HALT : STAT_RUN);
        pending_states.push_back(next_state);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    function void check_state(logic [7:0] pc_v, logic [7:0] acc_v, logic ov,
                              logic [7:0] ob, logic [1:0] st);
        machine_state_t want;
        if (pending_states.size() == 0)
        begin
            $error("response with no request outstanding: pc_value %0h", pc_v);
            error_count++;
            return;
        end
        want = pending_states.pop_front();
        compare_field("pc_value", want.pc_value, pc_v);
        compare_field("acc_value", want.acc_value, acc_v);
        compare_field("out_valid", {7'd0, want.out_valid}, {7'd0, ov});
        compare_field("out_byte", want.out_byte, ob);
        compare_field("status", {6'd0, want.status}, {6'd0, st});
    endfunction
endclass

module tb;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         RANDOM_ITEMS = 750;

    logic clk;
    logic rst_n;

    acpu_req_if req_ch ();
    acpu_rsp_if rsp_ch ();

    accumulator_cpu_step i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cpu_step_scoreboard sb = new();

    int  burst_left = 0;
    int  items_sent = 0;
    bit  long_hold_req = 1'b0;
    int  cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            sb.check_state(rsp_ch.pc_value, rsp_ch.acc_value, rsp_ch.out_valid,
                           rsp_ch.out_byte, rsp_ch.status);
        end
    end

    // Response side: stretches of full rate, random stalls and a fixed pattern,
    // plus one long hold-off on request from the stimulus.
    initial
    begin : ready_pattern
        int span;
        int style;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    rsp_ch.ready <= 1'b0;
                    repeat (300) @(negedge clk);
                end
                case (style)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ((i % 4) != 3);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [1:0] kind, input logic [7:0] addr,
                                input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.address <= addr;
        req_ch.data <= data;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(kind, addr, data);
        burst_left--;
        if (kind != KIND_SPARE)
        begin
            items_sent++;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (sb.pending_states.size() != 0);
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] code;
        case ($urandom_range(0, 20))
            0:       code = OPC_LOAD_IMM;
            1:       code = OPC_LOAD_DIR;
            2:       code = OPC_LOAD_IND;
            3:       code = OPC_ADD_IMM;
            4:       code = OPC_ADD_DIR;
            5:       code = OPC_ADD_IND;
            6:       code = OPC_SUB_IMM;
            7:       code = OPC_SUB_DIR;
            8:       code = OPC_SUB_IND;
            9:       code = OPC_NAND_IMM;
            10:      code = OPC_NAND_DIR;
            11:      code = OPC_NAND_IND;
            12:      code = OPC_STORE_DIR;
            13:      code = OPC_STORE_IND;
            14:      code = OPC_IN_DIR;
            15:      code = OPC_IN_IND;
            16:      code = OPC_OUT_DIR;
            17:      code = OPC_OUT_IND;
            18:      code = OPC_JUMP;
            19:      code = OPC_BRN;
            default: code = OPC_BRZ;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] pick_illegal();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (sb.op_class(code) != OC_ILL);
        return code;
    endfunction

    // Fill any byte the next execute would read but that was never written.
    task automatic prepare_fetch();
        logic [7:0] hole;
        bit         is_code;
        while (sb.find_unwritten_read(hole, is_code))
        begin
            send_request(KIND_LOAD, hole, is_code ? pick_opcode() : 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_directed();
        send_request(KIND_SPARE, 8'hFF, 8'hFF);
        // execute at PC 0 still runs; add wraps to zero; branch to 0 halts
        send_request(KIND_LOAD, 8'h00, OPC_LOAD_IMM);
        send_request(KIND_LOAD, 8'h01, 8'hFF);
        send_request(KIND_EXEC, 8'h00, 8'h00);
        send_request(KIND_LOAD, 8'h02, OPC_ADD_IMM);
        send_request(KIND_LOAD, 8'h03, 8'h01);
        send_request(KIND_EXEC, 8'hFF, 8'hFF);
        send_request(KIND_LOAD, 8'h04, OPC_BRZ);
        send_request(KIND_LOAD, 8'h05, 8'h00);
        send_request(KIND_EXEC, 8'h00, 8'h00);
        send_request(KIND_EXEC, 8'h00, 8'h00);
        // opcode at FF takes its operand from address 0
        send_request(KIND_LOAD, 8'hFF, OPC_BRN);
        send_request(KIND_START, 8'hFF, 8'h00);
        send_request(KIND_EXEC, 8'h00, 8'h00);
        // illegal opcode, frozen while faulted, loads still land, start clears
        send_request(KIND_LOAD, 8'h80, 8'hFF);
        send_request(KIND_LOAD, 8'h81, 8'h00);
        send_request(KIND_START, 8'h80, 8'h00);
        send_request(KIND_EXEC, 8'h00, 8'h00);
        send_request(KIND_EXEC, 8'h00, 8'hFF);
        send_request(KIND_LOAD, 8'h82, OPC_OUT_DIR);
        send_request(KIND_LOAD, 8'h83, 8'h81);
        send_request(KIND_START, 8'h82, 8'h00);
        send_request(KIND_EXEC, 8'h00, 8'h00);
        send_request(KIND_LOAD, 8'h84, OPC_IN_IND);
        send_request(KIND_LOAD, 8'h85, 8'h83);
        send_request(KIND_EXEC, 8'h00, 8'hFF);
    endtask

    task automatic inject_noise();
        case ($urandom_range(0, 2))
            0: send_request(KIND_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            1: send_request(KIND_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default:
            begin
                send_request(KIND_START, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                repeat (2)
                begin
                    prepare_fetch();
                    send_request(KIND_EXEC, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                end
            end
        endcase
    endtask

    task automatic run_program();
        logic [7:0] base;
        logic [7:0] code;
        logic [7:0] opnd;
        logic [7:0] entry;
        int         len;
        int         steps;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(2, 8);
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            code = ($urandom_range(0, 24) == 0) ? pick_illegal() : pick_opcode();
            case (sb.op_class(code))
                OC_JUMP, OC_BRN, OC_BRZ:
                    opnd = ($urandom_range(0, 7) == 0) ? 8'h00
                                                       : base + 8'(2 * $urandom_range(0, len));
                default:
                    opnd = 8'($urandom_range(0, 255));
            endcase
            send_request(KIND_LOAD, base + 8'(2 * i), code);
            send_request(KIND_LOAD, base + 8'(2 * i + 1), opnd);
        end
        // now and then enter off the instruction boundary
        entry = ($urandom_range(0, 9) == 0) ? base + 8'd1 : base;
        send_request(KIND_START, entry, 8'($urandom_range(0, 255)));
        steps = $urandom_range(len, 3 * len);
        for (int s = 0; s < steps; s++)
        begin
            prepare_fetch();
            send_request(KIND_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (sb.fault_q && $urandom_range(0, 1) == 0)
            begin
                break;
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            inject_noise();
        end
        if ($urandom_range(0, 9) == 0)
        begin
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_LOAD;
        req_ch.address = 8'h00;
        req_ch.data = 8'h00;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        wait_drained();
        long_hold_req = 1'b1;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            run_program();
        end
        wait_drained();
        repeat (20) @(negedge clk);
        if (sb.error_count == 0 && sb.pending_states.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
